// ===== design/onewire_rom_search_engine_defines.svh =====
// assertion macros used by the search engine core
`ifndef ONEWIRE_ROM_SEARCH_ENGINE_DEFINES_SVH
`define ONEWIRE_ROM_SEARCH_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define ORS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("onewire search engine check failed");

// condition that must never hold outside reset
`define ORS_ASSERT_NEVER(lbl, cond) \
  `ORS_ASSERT(lbl, !(cond))

`else

`define ORS_ASSERT(lbl, prop)
`define ORS_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== design/ors_pkg.sv =====
`default_nettype none

package ors_pkg;

  // width of a bit position, counts 1 to 64
  localparam int unsigned POS_W = 7;
  localparam int unsigned ROM_CODE_W = 64;

  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [7:0] FAMILY_RESET = 8'h28;

  // input command codes
  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_BEGIN    = 2'd1,
    CMD_BIT_PAIR = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_CONTINUE    = 3'd0,
    ST_FOUND       = 3'd1,
    ST_BAD_CODE    = 3'd2,
    ST_NO_RESPONSE = 3'd3,
    ST_EXHAUSTED   = 3'd4,
    ST_IDLE        = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0] command;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } in_item_t;

  typedef struct packed {
    logic                  direction;
    status_e               status;
    logic [ROM_CODE_W-1:0] rom_code;
    logic                  last_found;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/ors_in_if.sv =====
`default_nettype none

interface ors_in_if import ors_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/ors_out_if.sv =====
`default_nettype none

interface ors_out_if import ors_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/ors_in_stage.sv =====
`default_nettype none

module ors_in_stage import ors_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     advance_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // room when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload held without reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== design/ors_core.sv =====
`default_nettype none

`include "onewire_rom_search_engine_defines.svh"

module ors_core import ors_pkg::*; #(
  parameter int unsigned ROM_BYTES = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       advance_i,
  input  wire in_item_t   item_i,
  output out_item_t       item_o
);

  localparam int unsigned TOTAL_BITS = ROM_BYTES * 8;
  localparam int unsigned IDX_W      = $clog2(TOTAL_BITS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(TOTAL_BITS);
  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

  logic [TOTAL_BITS-1:0] rom_q, rom_d;
  logic [POS_W-1:0]      last_disc_q, last_disc_d;
  logic [POS_W-1:0]      zero_fork_q, zero_fork_d;
  logic [POS_W-1:0]      bit_pos_q, bit_pos_d;
  logic [7:0]            crc_q, crc_d;
  logic                  last_dev_q, last_dev_d;
  logic                  pass_q, pass_d;
  logic [7:0]            family_q;

  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic             dir;
  status_e          status;

  // current position, forced back to the first bit if out of range
  assign pos = ((bit_pos_q == '0) || (bit_pos_q > LAST_POS)) ? POS_ONE : bit_pos_q;
  assign idx = IDX_W'(pos - POS_ONE);

  // search decision for the item at the head of the input stage
  always_comb begin
    rom_d       = rom_q;
    last_disc_d = last_disc_q;
    zero_fork_d = zero_fork_q;
    bit_pos_d   = bit_pos_q;
    crc_d       = crc_q;
    last_dev_d  = last_dev_q;
    pass_d      = pass_q;
    dir         = 1'b0;
    status      = ST_IDLE;
    case (item_i.command)
      CMD_CLEAR: begin
        rom_d       = '0;
        last_disc_d = '0;
        zero_fork_d = '0;
        bit_pos_d   = POS_ONE;
        crc_d       = '0;
        last_dev_d  = 1'b0;
        pass_d      = 1'b0;
      end
      CMD_BEGIN: begin
        if (last_dev_q || !item_i.presence) begin
          pass_d = 1'b0;
          status = ST_EXHAUSTED;
        end else begin
          pass_d      = 1'b1;
          bit_pos_d   = POS_ONE;
          zero_fork_d = '0;
          crc_d       = '0;
          status      = ST_CONTINUE;
        end
      end
      CMD_BIT_PAIR: begin
        if (pass_q) begin
          if (item_i.id_bit && item_i.complement_bit) begin
            pass_d = 1'b0;
            status = ST_NO_RESPONSE;
          end else begin
            if (item_i.id_bit != item_i.complement_bit) begin
              dir = item_i.id_bit;
            end else begin
              // discrepancy: repeat earlier path, take 1 at the last one, else 0
              if (pos < last_disc_q) begin
                dir = rom_q[idx];
              end else begin
                dir = (pos == last_disc_q);
              end
              if (!dir) begin
                zero_fork_d = pos;
              end
            end
            rom_d[idx] = dir;
            // reflected crc8, one bit a step
            crc_d = {1'b0, crc_q[7:1]} ^ ((crc_q[0] ^ dir) ? CRC_POLY : 8'h00);
            if (pos >= LAST_POS) begin
              last_disc_d = zero_fork_d;
              last_dev_d  = (zero_fork_d == '0);
              pass_d      = 1'b0;
              bit_pos_d   = POS_ONE;
              if ((crc_d == '0) && (rom_d[7:0] == family_q)) begin
                status = ST_FOUND;
              end else begin
                status = ST_BAD_CODE;
              end
            end else begin
              bit_pos_d = pos + POS_ONE;
              status    = ST_CONTINUE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result of this item, loaded into the output stage on advance
  always_comb begin
    item_o.direction  = dir;
    item_o.status     = status;
    item_o.rom_code   = ROM_CODE_W'(rom_d);
    item_o.last_found = last_dev_d;
  end

  // search state, updated once per transfer into the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q       <= '0;
      last_disc_q <= '0;
      zero_fork_q <= '0;
      bit_pos_q   <= POS_ONE;
      crc_q       <= '0;
      last_dev_q  <= 1'b0;
      pass_q      <= 1'b0;
    end else if (advance_i) begin
      rom_q       <= rom_d;
      last_disc_q <= last_disc_d;
      zero_fork_q <= zero_fork_d;
      bit_pos_q   <= bit_pos_d;
      crc_q       <= crc_d;
      last_dev_q  <= last_dev_d;
      pass_q      <= pass_d;
    end
  end

  // family code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q <= FAMILY_RESET;
    end else if (cfg_we_i) begin
      family_q <= cfg_wdata_i;
    end
  end

  `ORS_ASSERT(a_pos_range, (bit_pos_q != '0) && (bit_pos_q <= LAST_POS))
  `ORS_ASSERT(a_clear_resets,
      (advance_i && (item_i.command == CMD_CLEAR)) |=>
      (!pass_q && !last_dev_q && (bit_pos_q == POS_ONE) && (crc_q == '0)))
  `ORS_ASSERT(a_pass_ends,
      (advance_i && pass_q && (item_i.command == CMD_BIT_PAIR) && (pos == LAST_POS) &&
       !(item_i.id_bit && item_i.complement_bit)) |=> (!pass_q && (bit_pos_q == POS_ONE)))
  `ORS_ASSERT_NEVER(a_no_pass_when_done, pass_q && last_dev_q)

endmodule

`default_nettype wire

// ===== design/ors_out_stage.sv =====
`default_nettype none

module ors_out_stage import ors_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_item_t item_i,
  output logic           can_load_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // free when empty or when the held result leaves this cycle
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// ===== design/onewire_rom_search_engine.sv =====
// 1-Wire ROM search decision engine
// in_i carries commands (clear, begin pass, bit pair) with the presence flag
// and the two read slots; out_o gives one result per command: the direction
// bit to write, a status code, the ROM code gathered so far and the last
// device flag. The user writes the family code register through cfg_we_i
// and cfg_wdata_i only while no command is in flight, unchecked by the block.
// Each command passes an input register, the decision and CRC logic, and
// an output register: the result is registered in the output register
// when the command moves on from the input register; one command is taken
// every cycle while the receiver holds ready high.
// The output register lets the next command be taken while a result still
// waits; when the receiver holds ready low, both registers fill and in_i
// ready falls until a result is taken. The search state moves on only when
// a command passes into the output register.
// Reset clears the enumeration (no pass open, bit position one, ROM code
// and CRC zero), empties both registers and sets the family code to 0x28.
`default_nettype none

module onewire_rom_search_engine import ors_pkg::*; #(
  parameter int unsigned ROM_BYTES = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  ors_in_if.sink          in_i,
  ors_out_if.source       out_o
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      can_load;
  logic      advance;
  out_item_t result;

  // a held command moves on when the output register has room
  assign advance = s1_valid && can_load;

  ors_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_i.data),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  ors_core #(
    .ROM_BYTES (ROM_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (s1_item),
    .item_o      (result)
  );

  ors_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .item_i      (result),
    .can_load_o  (can_load),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.data)
  );

endmodule

`default_nettype wire
